// ----- design/xhim_pkg.sv -----
// ----------------------------------------------------------------------------
// xhim_pkg
// Shared types, constants and the XTEA mixing function for the handle id
// mixer.
// ----------------------------------------------------------------------------
package xhim_pkg;

    localparam int WORD_W    = 32;
    localparam int KEYS      = 4;
    localparam int CFG_IDX_W = 8;

    localparam logic [WORD_W-1:0] MIX_DELTA = 32'h9E3779B9;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 8'd3;

    typedef logic [KEYS-1:0][WORD_W-1:0] t_key;

    typedef struct packed {
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] a;
    } t_words;

    function automatic logic [WORD_W-1:0] mix_f(input logic [WORD_W-1:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

// ----- design/xhim_key_regs.sv -----
// ----------------------------------------------------------------------------
// xhim_key_regs
// Holds the four 32-bit key words, written through the configuration channel.
// ----------------------------------------------------------------------------
module xhim_key_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [xhim_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [xhim_pkg::WORD_W-1:0]    i_cfg_data,
    output xhim_pkg::t_key                 o_key
);

    xhim_pkg::t_key r_key;
    xhim_pkg::t_key n_key;
    logic           w_hit;

    assign o_cfg_ready = 1'b1;
    // drop writes beyond the last key word
    assign w_hit = i_cfg_valid && (i_cfg_index <= xhim_pkg::REG_KEY_WORD_3);

    always_comb begin
        n_key = r_key;
        if (w_hit) begin
            n_key[i_cfg_index[1:0]] = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else begin
            r_key <= n_key;
        end
    end

    assign o_key = r_key;

    a_key_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |=> r_key[$past(i_cfg_index[1:0])] == $past(i_cfg_data))
        else $error("key word not updated by config write");

    a_key_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && (i_cfg_index > xhim_pkg::REG_KEY_WORD_3)) |=> $stable(r_key))
        else $error("out-of-range config write changed the key");

    a_key_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_valid |=> $stable(r_key))
        else $error("key changed without a config write");

endmodule

// ----- design/xhim_half_round.sv -----
// ----------------------------------------------------------------------------
// xhim_half_round
// One pipeline stage: one half of an XTEA cycle with its running sum and key
// word fixed by the stage position.
// ----------------------------------------------------------------------------
module xhim_half_round #(
    parameter int STAGE           = 0,
    parameter int CYCLES_PER_PASS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  xhim_pkg::t_words i_words,
    input  xhim_pkg::t_key   i_key,
    output logic             o_valid,
    output xhim_pkg::t_words o_words
);

    localparam int ROUND   = STAGE / 2;
    localparam int HALF    = STAGE % 2;
    localparam int PASS    = ROUND / CYCLES_PER_PASS;
    localparam int SUM_IDX = ROUND + HALF;
    localparam longint SUM_FULL = longint'(SUM_IDX) * longint'(xhim_pkg::MIX_DELTA);
    localparam logic [xhim_pkg::WORD_W-1:0] SUM = SUM_FULL[xhim_pkg::WORD_W-1:0];
    localparam logic [1:0] KEY_SEL = (HALF == 0) ? SUM[1:0] : SUM[12:11];

    logic                        r_valid;
    xhim_pkg::t_words            r_words;
    xhim_pkg::t_words            n_words;
    logic [xhim_pkg::WORD_W-1:0] w_keyed;
    logic [xhim_pkg::WORD_W-1:0] w_y;
    logic [xhim_pkg::WORD_W-1:0] w_y_new;

    // the user must keep the key static while items are in flight; this block does not enforce it
    assign w_keyed = SUM + i_key[KEY_SEL];

    always_comb begin
        n_words = i_words;
        w_y     = (PASS == 0) ? i_words.a : i_words.c;
        w_y_new = w_y + (xhim_pkg::mix_f(i_words.b) ^ w_keyed);
        if (HALF == 0) begin
            if (PASS == 0) begin
                n_words.a = w_y_new;
            end else begin
                n_words.c = w_y_new;
            end
        end else begin
            n_words.b = i_words.b + (xhim_pkg::mix_f(w_y) ^ w_keyed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_words <= n_words;
        end
    end

    assign o_valid = r_valid;
    assign o_words = r_words;

endmodule

// ----- design/xtea_handle_id_mixer_core.sv -----
// ----------------------------------------------------------------------------
// xtea_handle_id_mixer_core
// Mixes a 64-bit serial into three 32-bit identifier words under a 128-bit key.
// ----------------------------------------------------------------------------
// Takes one serial per cycle when the chain is not stalled and returns its three
// identifier words through the chain, one result per cycle under the same condition.
// The path is the chain of half-round stages: each register stage does one
// half of an XTEA cycle, in two passes (a with b, then c with b), and the
// last stage is the output register. The whole chain advances when the output
// register is empty or its beat is taken. Load the key words only while no
// serial is in flight.
module xtea_handle_id_mixer_core #(
    parameter int CYCLES_PER_PASS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [xhim_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [xhim_pkg::WORD_W-1:0]    i_cfg_data,
    // serial stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [63:0]                    i_s_tdata,  // serial_number[63:0]
    // identifier stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [95:0]                    o_m_tdata   // id_word_0, id_word_1, id_word_2
);

    localparam int STAGES = 4 * CYCLES_PER_PASS;

    xhim_pkg::t_key   w_key;
    logic             w_en;
    logic             w_valid [STAGES+1];
    xhim_pkg::t_words w_words [STAGES+1];

    xhim_key_regs u_key_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (w_key)
    );

    // advance the whole chain unless the output beat is stuck
    assign w_en       = !w_valid[STAGES] || i_m_tready;
    assign o_s_tready = w_en;

    assign w_valid[0] = i_s_tvalid;
    // c starts at zero, b takes the low half, a the high half
    assign w_words[0] = {{xhim_pkg::WORD_W{1'b0}}, i_s_tdata[31:0], i_s_tdata[63:32]};

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        xhim_half_round #(
            .STAGE           (g),
            .CYCLES_PER_PASS (CYCLES_PER_PASS)
        ) u_half_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_words (w_words[g]),
            .i_key   (w_key),
            .o_valid (w_valid[g+1]),
            .o_words (w_words[g+1])
        );
    end

    assign o_m_tvalid = w_valid[STAGES];
    assign o_m_tdata  = {w_words[STAGES].c, w_words[STAGES].b, w_words[STAGES].a};

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> w_valid[1])
        else $error("accepted serial did not enter the first stage");

    a_hold_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_valid[1]) && $stable(w_words[1]))
        else $error("first stage moved during a stall");

    a_shift_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_valid[STAGES-1]) |=> o_m_tvalid)
        else $error("item lost at the output stage");

endmodule
